@@ rtl/rsph_pkg.sv @@
// Package for the run-length-encoded sprite point hit test.
// Holds the parser phase type, the parser state record and the status and register codes.
// No dependencies.
`default_nettype none

package rsph_pkg;

  // Parser phase: which byte of the line stream is expected next.
  typedef enum logic [3:0] {
    PH_LEN_LO    = 4'd0,
    PH_LEN_HI    = 4'd1,
    PH_X_LO      = 4'd2,
    PH_X_HI      = 4'd3,
    PH_Y_LO      = 4'd4,
    PH_Y_HI      = 4'd5,
    PH_RUN_COUNT = 4'd6,
    PH_SKIP      = 4'd7
  } rsph_phase_t;

  // Result codes.
  localparam logic [1:0] STATUS_BUSY = 2'd0;
  localparam logic [1:0] STATUS_HIT  = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 4'd1;

  // Complete parser state carried from one byte to the next.
  typedef struct packed {
    rsph_phase_t phase;
    logic [7:0]  held_low_byte;
    logic [14:0] line_length;
    logic        line_encoded;
    logic [15:0] line_x;
    logic [15:0] pixels_covered;
    logic [14:0] bytes_to_skip;
    logic [1:0]  final_status;
  } rsph_state_t;

endpackage

`default_nettype wire

@@ rtl/rsph_parse.sv @@
// Next-state logic of the sprite line parser: one byte moves the state one step.
// Purely combinational; depends on rsph_pkg.
`default_nettype none

module rsph_parse (
  input  var rsph_pkg::rsph_state_t st_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic [15:0]          query_x_i,
  input  wire logic [15:0]          query_y_i,
  output var rsph_pkg::rsph_state_t st_o
);

  logic               active;
  logic [15:0]        word;
  logic               word_zero;
  logic signed [17:0] qx_ext;
  logic signed [17:0] lx_ext;
  logic signed [17:0] lo_bound;
  logic signed [17:0] hi_bound;
  logic               hit;
  logic [6:0]         run_cnt;
  logic [14:0]        run_skip;
  logic [15:0]        cov_run;
  logic               more_after_run;
  logic               more_after_skip;
  logic               len_nonzero;
  rsph_pkg::rsph_phase_t phase_nxt;

  // Shared decode of the incoming byte against the held state.
  assign active      = (st_i.final_status == rsph_pkg::STATUS_BUSY);
  assign word        = {data_byte_i, st_i.held_low_byte};
  assign word_zero   = (word == 16'd0);
  assign len_nonzero = (st_i.line_length != 15'd0);

  // Hit window x-1 .. x+length, widened so that no bound can overflow.
  assign qx_ext   = $signed({{2{query_x_i[15]}}, query_x_i});
  assign lx_ext   = $signed({{2{st_i.line_x[15]}}, st_i.line_x});
  assign lo_bound = lx_ext - 18'sd1;
  assign hi_bound = lx_ext + $signed({3'b000, st_i.line_length});
  assign hit      = (query_y_i == word) && (qx_ext >= lo_bound) && (qx_ext <= hi_bound);

  // Run record decode: odd counts carry one repeated pixel, even ones count>>1 literals.
  assign run_cnt         = data_byte_i[7:1];
  assign run_skip        = data_byte_i[0] ? 15'd1 : {8'd0, run_cnt};
  assign cov_run         = st_i.pixels_covered + {9'd0, run_cnt};
  assign more_after_run  = st_i.line_encoded && (cov_run < {1'b0, st_i.line_length});
  assign more_after_skip = st_i.line_encoded
                           && (st_i.pixels_covered < {1'b0, st_i.line_length});

  // Next phase.
  always_comb begin
    phase_nxt = st_i.phase;
    if (active) begin
      case (st_i.phase)
        rsph_pkg::PH_LEN_LO: phase_nxt = rsph_pkg::PH_LEN_HI;
        rsph_pkg::PH_LEN_HI: begin
          if (!word_zero) begin
            phase_nxt = rsph_pkg::PH_X_LO;
          end
        end
        rsph_pkg::PH_X_LO: phase_nxt = rsph_pkg::PH_X_HI;
        rsph_pkg::PH_X_HI: phase_nxt = rsph_pkg::PH_Y_LO;
        rsph_pkg::PH_Y_LO: phase_nxt = rsph_pkg::PH_Y_HI;
        rsph_pkg::PH_Y_HI: begin
          if (!hit) begin
            if (!len_nonzero) begin
              phase_nxt = rsph_pkg::PH_LEN_LO;
            end else if (st_i.line_encoded) begin
              phase_nxt = rsph_pkg::PH_RUN_COUNT;
            end else begin
              phase_nxt = rsph_pkg::PH_SKIP;
            end
          end
        end
        rsph_pkg::PH_RUN_COUNT: begin
          if (run_skip != 15'd0) begin
            phase_nxt = rsph_pkg::PH_SKIP;
          end else if (more_after_run) begin
            phase_nxt = rsph_pkg::PH_RUN_COUNT;
          end else begin
            phase_nxt = rsph_pkg::PH_LEN_LO;
          end
        end
        rsph_pkg::PH_SKIP: begin
          if (st_i.bytes_to_skip > 15'd1) begin
            phase_nxt = rsph_pkg::PH_SKIP;
          end else if (more_after_skip) begin
            phase_nxt = rsph_pkg::PH_RUN_COUNT;
          end else begin
            phase_nxt = rsph_pkg::PH_LEN_LO;
          end
        end
        default: phase_nxt = rsph_pkg::PH_LEN_LO;
      endcase
    end
  end

  // Data fields of the state.
  always_comb begin
    st_o       = st_i;
    st_o.phase = phase_nxt;
    if (active) begin
      case (st_i.phase)
        rsph_pkg::PH_LEN_LO,
        rsph_pkg::PH_X_LO,
        rsph_pkg::PH_Y_LO: st_o.held_low_byte = data_byte_i;
        rsph_pkg::PH_LEN_HI: begin
          if (word_zero) begin
            st_o.final_status = rsph_pkg::STATUS_MISS;
          end else begin
            st_o.line_encoded = word[0];
            st_o.line_length  = word[15:1];
          end
        end
        rsph_pkg::PH_X_HI: st_o.line_x = word;
        rsph_pkg::PH_Y_HI: begin
          if (hit) begin
            st_o.final_status = rsph_pkg::STATUS_HIT;
          end else begin
            st_o.pixels_covered = 16'd0;
            if (!st_i.line_encoded && len_nonzero) begin
              st_o.bytes_to_skip = st_i.line_length;
            end
          end
        end
        rsph_pkg::PH_RUN_COUNT: begin
          st_o.bytes_to_skip  = run_skip;
          st_o.pixels_covered = cov_run;
        end
        rsph_pkg::PH_SKIP: begin
          if (st_i.bytes_to_skip > 15'd1) begin
            st_o.bytes_to_skip = st_i.bytes_to_skip - 15'd1;
          end else begin
            st_o.bytes_to_skip = 15'd0;
          end
        end
        default: st_o.bytes_to_skip = st_i.bytes_to_skip;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/rle_sprite_point_hit_test.sv @@
// Point hit test against a run-length-encoded sprite frame, one byte per transaction.
// The status for a byte is registered and presented in the cycle after the byte's transaction.
// Throughput: one byte per cycle while the result channel does not stall; a single output register buffers the result.
// Synchronous active-low reset clears the parser, the query registers and the output valid.
// Depends on rsph_pkg and rsph_parse.
`default_nettype none

module rle_sprite_point_hit_test (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Configuration write channel
  input  wire logic                          cfg_valid,
  output wire logic                          cfg_ready,
  input  wire logic [rsph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data,
  // Input byte channel
  input  wire logic                          in_valid,
  output wire logic                          in_stall,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_first,
  // Result channel
  output wire logic                          out_valid,
  input  wire logic                          out_stall,
  output wire logic [1:0]                    out_status
);

  logic [15:0]           query_x_r;
  logic [15:0]           query_y_r;
  rsph_pkg::rsph_state_t state_r;
  rsph_pkg::rsph_state_t state_cur;
  rsph_pkg::rsph_state_t state_nxt;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic                  in_take;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r <= 16'd0;
      query_y_r <= 16'd0;
    end else if (cfg_valid) begin
      if (cfg_index == rsph_pkg::REG_QUERY_X) begin
        query_x_r <= cfg_data;
      end
      if (cfg_index == rsph_pkg::REG_QUERY_Y) begin
        query_y_r <= cfg_data;
      end
    end
  end

  // Input is held off only while a result is waiting and the consumer stalls.
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // A first byte restarts the parser before the byte itself is parsed.
  always_comb begin
    state_cur = state_r;
    if (in_first) begin
      state_cur.phase          = rsph_pkg::PH_LEN_LO;
      state_cur.held_low_byte  = 8'd0;
      state_cur.line_length    = 15'd0;
      state_cur.line_encoded   = 1'b0;
      state_cur.line_x         = 16'd0;
      state_cur.pixels_covered = 16'd0;
      state_cur.bytes_to_skip  = 15'd0;
      state_cur.final_status   = rsph_pkg::STATUS_BUSY;
    end
  end

  rsph_parse u_parse (
    .st_i        (state_cur),
    .data_byte_i (in_data_byte),
    .query_x_i   (query_x_r),
    .query_y_i   (query_y_r),
    .st_o        (state_nxt)
  );

  // Parser state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase          <= rsph_pkg::PH_LEN_LO;
      state_r.held_low_byte  <= 8'd0;
      state_r.line_length    <= 15'd0;
      state_r.line_encoded   <= 1'b0;
      state_r.line_x         <= 16'd0;
      state_r.pixels_covered <= 16'd0;
      state_r.bytes_to_skip  <= 15'd0;
      state_r.final_status   <= rsph_pkg::STATUS_BUSY;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // Output register: loaded with each new status, cleared once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_status_r <= state_nxt.final_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

@@ rtl/rsph_checker.sv @@
// Port-level checker for the sprite point hit test, bound to the top level.
// Depends only on the ports of rle_sprite_point_hit_test.
`default_nettype none

module rsph_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_status
);

  // A stalled result stays presented and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result changed or was dropped");

  // Every accepted byte produces a result in the following cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted byte produced no result");

  // Input is held off only while a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no blocked result");

  // A presented status code never takes the unused encoding.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("illegal status code");

endmodule

bind rle_sprite_point_hit_test rsph_checker u_rsph_checker (.*);

`default_nettype wire
